### rtl/core/srrb_pkg.sv
// ----------------------------------------------------------------------------
// Session round-robin balancer package
// Shared codes, beat layouts and types for the balancer core and its units.
// ----------------------------------------------------------------------------
package srrb_pkg;

    // beat layout widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 88;
    localparam int TURN_W      = 16;

    // packets per turn after reset
    localparam logic [TURN_W-1:0] TURN_RESET = 16'd5;

    // request kinds carried in the slave-side tuser
    typedef enum logic [1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_SOURCE   = 2'd1,
        FUNC_REPLY    = 2'd2,
        FUNC_DUMP     = 2'd3
    } t_func;

    // result status carried in the master-side tuser
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_HOPS_FULL  = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_EMPTY      = 3'd4
    } t_status;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        ALU_CMP     = 2'd0,
        ALU_INC_SAT = 2'd1,
        ALU_INC16   = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic eq;
        logic a_zero;
        logic ge;
    } t_alu_flags;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_LOOK  = 3'd2,
        S_HOPRD = 3'd3,
        S_COUNT = 3'd4,
        S_TURN  = 3'd5,
        S_DUMP  = 3'd6,
        S_PUT   = 3'd7
    } t_state;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] count;
    } t_hop_entry;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic        first_hop;
        logic [31:0] target_addr;
        logic [15:0] target_port;
        logic [2:0]  hop_index;
        logic [31:0] hop_packets;
        logic        last;
    } t_result;

endpackage

### rtl/core/session_round_robin_balancer_core.sv
// ----------------------------------------------------------------------------
// Session round-robin balancer core
// Session table with hop registration, round-robin packet steering with
// saturating per-hop counts, reply steering and per-session stats dump.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request a beat: tuser holds the request kind, tdata
//   the session, source and destination fields. m_axis returns result beats
//   with the status in tuser and tlast on the final beat of a request.
//   The config channel writes packets_per_turn; write it only while idle.
// Sequence (one request at a time, tready low while it is worked on):
//   register : scans slots in order, 1..SESSION_SLOTS of them, to the result,
//              one slot table read per cycle through the shared compare unit
//   source   : slot read, hop read, count update, turn update
//   reply    : slot read only, likewise empty-session and mismatch results
//   dump     : slot read, hop read and dump step to the first beat, then again per further hop,
//              one hop table read per result beat
// Every request also returns to idle before the next beat is accepted.
// Reset empties all slots at once through per-slot valid bits and restores
// packets_per_turn to 5; hop cells are written when registered, so no sweep.
// A stalled receiver holds the output register; the core waits in its put
// step and resumes as soon as the beat is taken.
// ----------------------------------------------------------------------------
module session_round_robin_balancer_core #(
    parameter int SESSION_SLOTS    = 8,
    parameter int HOPS_PER_SESSION = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write: packets_per_turn
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srrb_pkg::TURN_W-1:0]        i_cfg_data,
    // requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: session[2:0], source_addr[34:3], source_port[50:35],
    //        dest_addr[82:51], dest_port[98:83], zero pad [103:99]
    input  logic [srrb_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]                         s_axis_tuser,
    // results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: slot[2:0], first_hop[3], target_addr[35:4], target_port[51:36],
    //        hop_index[54:52], hop_packets[86:55], zero pad [87]
    output logic [srrb_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import srrb_pkg::*;

    localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int HOP_W  = (HOPS_PER_SESSION > 1) ? $clog2(HOPS_PER_SESSION) : 1;
    localparam int HT_W   = $clog2(HOPS_PER_SESSION + 1);
    localparam int CELLS  = SESSION_SLOTS * HOPS_PER_SESSION;
    localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    typedef struct packed {
        logic [31:0]       src_addr;
        logic [15:0]       src_port;
        logic [HT_W-1:0]   hop_total;
        logic [HOP_W-1:0]  cur_hop;
        logic [TURN_W-1:0] turn;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    // input beat fields
    t_func       in_func;
    logic [2:0]  in_session;
    logic [31:0] in_saddr;
    logic [15:0] in_sport;
    logic [31:0] in_daddr;
    logic [15:0] in_dport;
    logic        in_accept;
    logic        sess_far;

    // registers
    t_state            r_state, n_state;
    t_func             r_func;
    logic [31:0]       r_saddr;
    logic [15:0]       r_sport;
    logic [31:0]       r_daddr;
    logic [15:0]       r_dport;
    logic [SLOT_W-1:0] r_slot_idx, n_slot_idx;
    logic [HOP_W-1:0]  r_hop, n_hop;
    t_slot             r_slot, n_slot;
    t_result           r_res, n_res;
    logic              r_more, n_more;
    logic              r_out_valid;
    t_result           r_out;
    logic [TURN_W-1:0] r_ppt;

    // table and unit signals
    logic [SLOT_W-1:0]    slot_raddr;
    logic                 slot_we;
    t_slot                slot_wdata;
    logic [SLOT_BITS-1:0] slot_rvec;
    t_slot                slot_rd;
    logic                 hop_we;
    logic [HOP_W-1:0]     hop_w_hop;
    t_hop_entry           hop_wdata;
    t_hop_entry           hop_rd;
    logic [CELL_W-1:0]    hop_raddr;
    logic [CELL_W-1:0]    hop_waddr;
    t_alu_op              alu_op;
    logic [31:0]          alu_a;
    logic [31:0]          alu_b;
    logic [31:0]          alu_res;
    t_alu_flags           alu_flags;
    logic [HOP_W-1:0]     look_hop;
    logic                 out_free;
    logic                 load_out;
    logic                 dump_last;

    function automatic logic [CELL_W-1:0] cell_of(input logic [SLOT_W-1:0] s,
                                                  input logic [HOP_W-1:0] h);
        cell_of = CELL_W'(s) * CELL_W'(HOPS_PER_SESSION) + CELL_W'(h);
    endfunction

    function automatic t_result blank_result(input t_status st, input logic [2:0] sl);
        t_result res;
        res        = '0;
        res.status = st;
        res.slot   = sl;
        res.last   = 1'b1;
        return res;
    endfunction

    // unpack the request beat
    assign in_func    = t_func'(s_axis_tuser);
    assign in_session = s_axis_tdata[2:0];
    assign in_saddr   = s_axis_tdata[34:3];
    assign in_sport   = s_axis_tdata[50:35];
    assign in_daddr   = s_axis_tdata[82:51];
    assign in_dport   = s_axis_tdata[98:83];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign sess_far   = (32'(in_session) >= 32'(SESSION_SLOTS));

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;

    // tables and shared unit
    assign slot_rd = t_slot'(slot_rvec);

    srrb_slot_ram #(
        .DEPTH  (SESSION_SLOTS),
        .WIDTH  (SLOT_BITS),
        .ADDR_W (SLOT_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (slot_raddr),
        .i_we    (slot_we),
        .i_waddr (r_slot_idx),
        .i_wdata (slot_wdata),
        .o_rdata (slot_rvec)
    );

    assign hop_raddr = cell_of(r_slot_idx, r_hop);
    assign hop_waddr = cell_of(r_slot_idx, hop_w_hop);

    srrb_hop_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (CELL_W)
    ) u_hop_ram (
        .i_clk   (i_clk),
        .i_raddr (hop_raddr),
        .i_we    (hop_we),
        .i_waddr (hop_waddr),
        .i_wdata (hop_wdata),
        .o_rdata (hop_rd)
    );

    srrb_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    // current hop, falling back to hop 0 for a single hop or a stale index
    assign look_hop = ((slot_rd.hop_total > HT_W'(1)) &&
                       (HT_W'(slot_rd.cur_hop) < slot_rd.hop_total)) ?
                      slot_rd.cur_hop : '0;
    assign dump_last = ((HT_W'(r_hop) + HT_W'(1)) == r_slot.hop_total);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
        end
    end

    // sequencer datapath registers
    always_ff @(posedge i_clk) begin
        r_slot_idx <= n_slot_idx;
        r_hop      <= n_hop;
        r_slot     <= n_slot;
        r_res      <= n_res;
        if (in_accept) begin
            r_func  <= in_func;
            r_saddr <= in_saddr;
            r_sport <= in_sport;
            r_daddr <= in_daddr;
            r_dport <= in_dport;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppt <= TURN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ppt <= i_cfg_data;
        end
    end

    // next state and table control
    always_comb begin
        n_state    = r_state;
        n_slot_idx = r_slot_idx;
        n_hop      = r_hop;
        n_slot     = r_slot;
        n_res      = r_res;
        n_more     = r_more;
        slot_raddr = r_slot_idx;
        slot_we    = 1'b0;
        slot_wdata = r_slot;
        hop_we     = 1'b0;
        hop_w_hop  = r_hop;
        hop_wdata  = '0;
        alu_op     = ALU_CMP;
        alu_a      = slot_rd.src_addr;
        alu_b      = r_saddr;
        load_out   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_func == FUNC_REGISTER || sess_far) begin
                    slot_raddr = '0;
                end else begin
                    slot_raddr = SLOT_W'(in_session);
                end
                if (in_accept) begin
                    n_more = 1'b0;
                    n_hop  = '0;
                    if (in_func == FUNC_REGISTER) begin
                        n_slot_idx = '0;
                        n_state    = S_SCAN;
                    end else if (sess_far) begin
                        n_res   = blank_result(ST_EMPTY, in_session);
                        n_state = S_PUT;
                    end else begin
                        n_slot_idx = SLOT_W'(in_session);
                        n_state    = S_LOOK;
                    end
                end
            end

            // walk the slots for an empty or matching one
            S_SCAN: begin
                if (r_slot_idx == SLOT_W'(SESSION_SLOTS - 1)) begin
                    slot_raddr = r_slot_idx;
                end else begin
                    slot_raddr = r_slot_idx + SLOT_W'(1);
                end
                if (alu_flags.eq || alu_flags.a_zero) begin
                    n_slot = slot_rd;
                    if (slot_rd.hop_total >= HT_W'(HOPS_PER_SESSION)) begin
                        n_res = blank_result(ST_HOPS_FULL, 3'(r_slot_idx));
                    end else begin
                        slot_we              = 1'b1;
                        slot_wdata           = slot_rd;
                        slot_wdata.src_addr  = r_saddr;
                        slot_wdata.hop_total = slot_rd.hop_total + HT_W'(1);
                        hop_we               = 1'b1;
                        hop_w_hop            = HOP_W'(slot_rd.hop_total);
                        hop_wdata.addr       = r_daddr;
                        hop_wdata.port       = r_dport;
                        hop_wdata.count      = 32'd0;
                        n_res                = blank_result(ST_OK, 3'(r_slot_idx));
                        n_res.first_hop      = (slot_rd.hop_total == '0);
                        n_res.target_addr    = r_daddr;
                        n_res.target_port    = r_dport;
                        n_res.hop_index      = 3'(slot_rd.hop_total);
                    end
                    n_state = S_PUT;
                end else if (r_slot_idx == SLOT_W'(SESSION_SLOTS - 1)) begin
                    n_res   = blank_result(ST_TABLE_FULL, 3'd0);
                    n_state = S_PUT;
                end else begin
                    n_slot_idx = r_slot_idx + SLOT_W'(1);
                end
            end

            // session slot is in; dispatch on the request kind
            S_LOOK: begin
                n_slot = slot_rd;
                if (slot_rd.hop_total == '0) begin
                    n_res   = blank_result(ST_EMPTY, 3'(r_slot_idx));
                    n_state = S_PUT;
                end else begin
                    case (r_func)
                        FUNC_SOURCE: begin
                            if (!alu_flags.eq) begin
                                n_res   = blank_result(ST_MISMATCH, 3'(r_slot_idx));
                                n_state = S_PUT;
                            end else begin
                                n_hop   = look_hop;
                                n_state = S_HOPRD;
                            end
                        end
                        FUNC_REPLY: begin
                            n_res             = blank_result(ST_OK, 3'(r_slot_idx));
                            n_res.target_addr = slot_rd.src_addr;
                            n_res.target_port = slot_rd.src_port;
                            n_state           = S_PUT;
                        end
                        default: begin
                            n_hop   = '0;
                            n_state = S_HOPRD;
                        end
                    endcase
                end
            end

            // hop table read in flight
            S_HOPRD: begin
                n_state = (r_func == FUNC_SOURCE) ? S_COUNT : S_DUMP;
            end

            // bump the hop count and steer the packet
            S_COUNT: begin
                alu_op            = ALU_INC_SAT;
                alu_a             = hop_rd.count;
                hop_we            = 1'b1;
                hop_wdata.addr    = hop_rd.addr;
                hop_wdata.port    = hop_rd.port;
                hop_wdata.count   = alu_res;
                n_res             = blank_result(ST_OK, 3'(r_slot_idx));
                n_res.target_addr = hop_rd.addr;
                n_res.target_port = hop_rd.port;
                n_res.hop_index   = 3'(r_hop);
                n_res.hop_packets = alu_res;
                n_state           = S_TURN;
            end

            // advance the turn counter and rotate when it runs out
            S_TURN: begin
                alu_op              = ALU_INC16;
                alu_a               = 32'(r_slot.turn);
                alu_b               = 32'(r_ppt);
                slot_we             = 1'b1;
                slot_wdata          = r_slot;
                slot_wdata.src_port = r_sport;
                if (r_slot.hop_total > HT_W'(1)) begin
                    if (alu_flags.ge) begin
                        slot_wdata.turn = '0;
                        if ((HT_W'(r_hop) + HT_W'(1)) == r_slot.hop_total) begin
                            slot_wdata.cur_hop = '0;
                        end else begin
                            slot_wdata.cur_hop = r_hop + HOP_W'(1);
                        end
                    end else begin
                        slot_wdata.turn = alu_res[TURN_W-1:0];
                    end
                end
                n_state = S_PUT;
            end

            // one dump beat per hop
            S_DUMP: begin
                n_res             = blank_result(ST_OK, 3'(r_slot_idx));
                n_res.target_addr = hop_rd.addr;
                n_res.target_port = hop_rd.port;
                n_res.hop_index   = 3'(r_hop);
                n_res.hop_packets = hop_rd.count;
                n_res.last        = dump_last;
                n_more            = !dump_last;
                n_state           = S_PUT;
            end

            // hand the result to the output register
            S_PUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_more) begin
                        n_hop   = r_hop + HOP_W'(1);
                        n_state = S_HOPRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {1'b0, r_out.hop_packets, r_out.hop_index, r_out.target_port,
                            r_out.target_addr, r_out.first_hop, r_out.slot};

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted but core still ready");

    a_put_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && out_free) |=> m_axis_tvalid)
        else $error("result not presented after put");

    a_dump_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && r_more) |-> !r_res.last)
        else $error("dump continues after last beat");

    a_slot_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot_we |-> (r_state == S_SCAN || r_state == S_TURN))
        else $error("slot table written outside register or turn step");
`endif

endmodule

### rtl/core/srrb_alu.sv
// ----------------------------------------------------------------------------
// Balancer shared arithmetic unit
// Compare, saturating increment and 16-bit wrapping increment, reused by the
// sequencer for slot matching, hop counting and turn counting.
// ----------------------------------------------------------------------------
module srrb_alu (
    input  srrb_pkg::t_alu_op    i_op,
    input  logic [31:0]          i_a,
    input  logic [31:0]          i_b,
    output logic [31:0]          o_res,
    output srrb_pkg::t_alu_flags o_flags
);
    import srrb_pkg::*;

    // select the operation
    always_comb begin
        case (i_op)
            ALU_CMP: begin
                o_res = i_a;
            end
            ALU_INC_SAT: begin
                o_res = (i_a == 32'hFFFF_FFFF) ? i_a : i_a + 32'd1;
            end
            ALU_INC16: begin
                o_res = {16'd0, i_a[15:0] + 16'd1};
            end
            default: begin
                o_res = i_a;
            end
        endcase
    end

    // flags for the sequencer's decisions
    always_comb begin
        o_flags.eq     = (i_a == i_b);
        o_flags.a_zero = (i_a == 32'd0);
        o_flags.ge     = (o_res >= i_b);
    end

endmodule

### rtl/core/srrb_slot_ram.sv
// ----------------------------------------------------------------------------
// Balancer session slot table
// One write port, one registered read port; a valid bit per slot makes a
// never-written slot read as all zeros after reset.
// ----------------------------------------------------------------------------
module srrb_slot_ram #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 70,
    parameter int ADDR_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_raddr,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    // track written slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

### rtl/core/srrb_hop_ram.sv
// ----------------------------------------------------------------------------
// Balancer hop table
// Destination and packet count per hop cell; one write port and one
// registered read port. Cells are written when their hop is registered.
// ----------------------------------------------------------------------------
module srrb_hop_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                   i_clk,
    input  logic [ADDR_W-1:0]      i_raddr,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  srrb_pkg::t_hop_entry   i_wdata,
    output srrb_pkg::t_hop_entry   o_rdata
);
    import srrb_pkg::*;

    t_hop_entry mem [DEPTH];

    // write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
